### design/mesh_text_frame_encoder_core_defines.svh
// Assertion macros shared by the frame encoder modules.
// MTFE_ASSERT is gated by the reset; MTFE_ASSERT_NR also holds during reset.
`ifndef MESH_TEXT_FRAME_ENCODER_CORE_DEFINES_SVH
`define MESH_TEXT_FRAME_ENCODER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define MTFE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define MTFE_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define MTFE_ASSERT(lbl, clk, rst_n, prop, msg)
`define MTFE_ASSERT_NR(lbl, clk, prop, msg)
`endif

`endif

### design/mtfe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mtfe_pkg;

  // depth of the command queue between front and back
  localparam int CmdDepth = 2;

  // longest payload a start may ask for
  localparam int unsigned MaxPayloadLen = 200;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_LEN     = 2'd1,
    ST_NOFRAME = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CMD_ERR  = 2'd0,
    CMD_HDR  = 2'd1,
    CMD_DATA = 2'd2
  } cmd_kind_e;

  // one classified input item
  typedef struct packed {
    cmd_kind_e  kind;
    status_e    stat;   // error code for CMD_ERR
    logic [7:0] value;  // length for CMD_HDR, payload byte for CMD_DATA
    logic       trl;    // trailer follows this command
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HEAD,
    S_LEN_VI,
    S_DEST_TAG,
    S_DEST_VI,
    S_NODE_TAG,
    S_NODE_VI,
    S_PKT_TAG,
    S_PKT_VI,
    S_HOP_TAG,
    S_HOP_VAL
  } back_state_e;

endpackage

`default_nettype wire

### design/mtfe_front.sv
`timescale 1ns / 1ps
`default_nettype none

module mtfe_front import mtfe_pkg::*; #(
  parameter int unsigned MaxPayload = MaxPayloadLen
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic       req_type_i,
  input  wire logic [7:0] frame_length_i,
  input  wire logic [7:0] data_byte_i,
  output cmd_t            cmd_o,
  output logic            cmd_push_o
);

  localparam logic [7:0] MaxLen = 8'(MaxPayload);

  logic       frame_open_q, frame_open_d;
  logic [7:0] bytes_left_q, bytes_left_d;

  // classify the item and track the open frame
  always_comb begin
    frame_open_d = frame_open_q;
    bytes_left_d = bytes_left_q;
    cmd_o.kind   = CMD_ERR;
    cmd_o.stat   = ST_OK;
    cmd_o.value  = '0;
    cmd_o.trl    = 1'b0;
    if (!req_type_i) begin
      if (frame_length_i > MaxLen) begin
        cmd_o.stat = ST_LEN;
      end else begin
        cmd_o.kind   = CMD_HDR;
        cmd_o.value  = frame_length_i;
        cmd_o.trl    = (frame_length_i == 8'd0);
        frame_open_d = (frame_length_i != 8'd0);
        bytes_left_d = frame_length_i;
      end
    end else if (!frame_open_q || bytes_left_q == 8'd0) begin
      cmd_o.stat = ST_NOFRAME;
    end else begin
      cmd_o.kind   = CMD_DATA;
      cmd_o.value  = data_byte_i;
      cmd_o.trl    = (bytes_left_q == 8'd1);
      bytes_left_d = bytes_left_q - 8'd1;
      frame_open_d = (bytes_left_q != 8'd1);
    end
  end

  assign cmd_push_o = accept_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_open_q <= 1'b0;
      bytes_left_q <= 8'd0;
    end else if (accept_i) begin
      frame_open_q <= frame_open_d;
      bytes_left_q <= bytes_left_d;
    end
  end

endmodule

`default_nettype wire

### design/mtfe_cmdq.sv
`timescale 1ns / 1ps
`default_nettype none

`include "mesh_text_frame_encoder_core_defines.svh"

module mtfe_cmdq import mtfe_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t cmd_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output cmd_t      cmd_o
);

  localparam int PtrW = (CmdDepth > 1) ? $clog2(CmdDepth) : 1;
  localparam int CntW = $clog2(CmdDepth + 1);

  cmd_t            slots_q [CmdDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            wr_en, rd_en;

  assign full_o  = (count_q == CntW'(CmdDepth));
  assign valid_o = (count_q != '0);
  assign cmd_o   = slots_q[rd_ptr_q];
  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && valid_o;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(CmdDepth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slots_q[wr_ptr_q] <= cmd_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (rd_en) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (wr_en && !rd_en) begin
        count_q <= count_q + CntW'(1);
      end else if (rd_en && !wr_en) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  `MTFE_ASSERT(a_no_push_full, clk_i, rst_ni, !(push_i && full_o), "push into full queue")
  `MTFE_ASSERT(a_no_pop_empty, clk_i, rst_ni, !(pop_i && !valid_o), "pop from empty queue")
  `MTFE_ASSERT(a_count_range, clk_i, rst_ni, count_q <= CntW'(CmdDepth), "queue count overflow")

endmodule

`default_nettype wire

### design/mtfe_back.sv
`timescale 1ns / 1ps
`default_nettype none

`include "mesh_text_frame_encoder_core_defines.svh"

module mtfe_back import mtfe_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        cmd_valid_i,
  input  wire cmd_t        cmd_i,
  output logic             cmd_pop_o,
  input  wire logic        pop_i,
  output logic             empty_o,
  output logic [7:0]       out_byte_o,
  output logic             end_of_frame_o,
  output logic [1:0]       status_o
);

  localparam logic [7:0]  HeaderByte    = 8'h33;
  localparam logic [7:0]  TagVersion    = 8'h08;
  localparam logic [7:0]  VersionVal    = 8'h01;
  localparam logic [7:0]  TagPayload    = 8'h12;
  localparam logic [7:0]  TagDest       = 8'h20;
  localparam logic [7:0]  TagNode       = 8'h28;
  localparam logic [7:0]  TagPkt        = 8'h30;
  localparam logic [7:0]  TagHop        = 8'h58;
  localparam logic [7:0]  HopCount      = 8'h03;
  localparam logic [31:0] BroadcastDest = 32'hFFFF_FFFF;

  back_state_e st_q, st_d;
  logic [1:0]  hdr_idx_q, hdr_idx_d;
  logic [31:0] vi_q, vi_d;
  logic        trl_q, trl_d;
  logic [31:0] pkt_q, pkt_d;
  logic [31:0] node_id_q;

  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic        out_eof_q;
  status_e     out_stat_q;

  logic        adv, emit, emit_eof, vi_more, trl_last;
  logic [7:0]  emit_byte;
  status_e     emit_stat;

  // output slot frees when empty or being taken this cycle
  assign adv      = !out_valid_q || pop_i;
  assign vi_more  = |vi_q[31:7];
  assign trl_last = emit && (st_q == S_HOP_VAL);

  // byte produced this cycle
  always_comb begin
    emit      = 1'b0;
    emit_byte = '0;
    emit_eof  = 1'b0;
    emit_stat = ST_OK;
    cmd_pop_o = 1'b0;
    unique case (st_q) inside
      S_IDLE: begin
        if (cmd_valid_i) begin
          emit      = adv;
          cmd_pop_o = adv;
          case (cmd_i.kind)
            CMD_ERR: begin
              emit_eof  = 1'b1;
              emit_stat = cmd_i.stat;
            end
            CMD_HDR:  emit_byte = HeaderByte;
            CMD_DATA: emit_byte = cmd_i.value;
            default:  emit_byte = '0;
          endcase
        end
      end
      S_HEAD: begin
        emit = adv;
        case (hdr_idx_q)
          2'd1:    emit_byte = TagVersion;
          2'd2:    emit_byte = VersionVal;
          default: emit_byte = TagPayload;
        endcase
      end
      S_LEN_VI, S_DEST_VI, S_NODE_VI, S_PKT_VI: begin
        emit      = adv;
        emit_byte = {vi_more, vi_q[6:0]};
      end
      S_DEST_TAG: begin
        emit      = adv;
        emit_byte = TagDest;
      end
      S_NODE_TAG: begin
        emit      = adv;
        emit_byte = TagNode;
      end
      S_PKT_TAG: begin
        emit      = adv;
        emit_byte = TagPkt;
      end
      S_HOP_TAG: begin
        emit      = adv;
        emit_byte = TagHop;
      end
      S_HOP_VAL: begin
        emit      = adv;
        emit_byte = HopCount;
        emit_eof  = 1'b1;
      end
      default: emit = 1'b0;
    endcase
  end

  // sequencer next state
  always_comb begin
    st_d      = st_q;
    hdr_idx_d = hdr_idx_q;
    vi_d      = vi_q;
    trl_d     = trl_q;
    pkt_d     = pkt_q;
    if (emit) begin
      unique case (st_q)
        S_IDLE: begin
          case (cmd_i.kind)
            CMD_HDR: begin
              st_d      = S_HEAD;
              hdr_idx_d = 2'd1;
              trl_d     = cmd_i.trl;
              vi_d      = {24'd0, cmd_i.value};
            end
            CMD_DATA: begin
              if (cmd_i.trl) begin
                st_d = S_DEST_TAG;
              end
            end
            default: st_d = S_IDLE;
          endcase
        end
        S_HEAD: begin
          hdr_idx_d = hdr_idx_q + 2'd1;
          if (hdr_idx_q == 2'd3) begin
            st_d = S_LEN_VI;
          end
        end
        S_LEN_VI: begin
          vi_d = vi_q >> 7;
          if (!vi_more) begin
            st_d = trl_q ? S_DEST_TAG : S_IDLE;
          end
        end
        S_DEST_TAG: begin
          vi_d = BroadcastDest;
          st_d = S_DEST_VI;
        end
        S_DEST_VI: begin
          vi_d = vi_q >> 7;
          if (!vi_more) begin
            st_d = S_NODE_TAG;
          end
        end
        S_NODE_TAG: begin
          vi_d = node_id_q;
          st_d = S_NODE_VI;
        end
        S_NODE_VI: begin
          vi_d = vi_q >> 7;
          if (!vi_more) begin
            st_d = S_PKT_TAG;
          end
        end
        S_PKT_TAG: begin
          vi_d = pkt_q;
          st_d = S_PKT_VI;
        end
        S_PKT_VI: begin
          vi_d = vi_q >> 7;
          if (!vi_more) begin
            st_d = S_HOP_TAG;
          end
        end
        S_HOP_TAG: st_d = S_HOP_VAL;
        S_HOP_VAL: begin
          pkt_d = pkt_q + 32'd1;
          st_d  = S_IDLE;
        end
        default: st_d = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_IDLE;
      pkt_q     <= '0;
      node_id_q <= '0;
    end else begin
      st_q  <= st_d;
      pkt_q <= pkt_d;
      if (cfg_we_i) begin
        node_id_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_idx_q <= hdr_idx_d;
    vi_q      <= vi_d;
    trl_q     <= trl_d;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q <= emit_byte;
      out_eof_q  <= emit_eof;
      out_stat_q <= emit_stat;
    end
  end

  assign empty_o        = !out_valid_q;
  assign out_byte_o     = out_byte_q;
  assign end_of_frame_o = out_eof_q;
  assign status_o       = out_stat_q;

  `MTFE_ASSERT(a_pkt_inc, clk_i, rst_ni, trl_last |=> (pkt_q == $past(pkt_q) + 32'd1), "pkt id stuck")
  `MTFE_ASSERT(a_err_idle, clk_i, rst_ni, (emit && emit_stat != ST_OK) |-> (st_q == S_IDLE), "err in frame")
  `MTFE_ASSERT(a_pop_idle, clk_i, rst_ni, cmd_pop_o |-> (st_q == S_IDLE && cmd_valid_i), "cmd taken busy")

endmodule

`default_nettype wire

### design/mesh_text_frame_encoder_core.sv
// Channel   Handshake              Beat
// --------  ---------------------  -----------------------------------------
// input     push / full            req_type_i, frame_length_i, data_byte_i
// result    empty / pop            out_byte_o, end_of_frame_o, status_o
// config    cfg_we_i               cfg_wdata_i (node id)
//
// The byte sequencer emits one result per cycle while its output is free:
// a payload byte or an error is one result, a start 5 to 6 bytes, a
// trailer 12 to 20 bytes. A two-entry command queue lets the classifier
// take items meanwhile, so unstalled payload bytes flow at one per cycle.
// Reset clears the frame state, the packet id and the node id at once.
// A stalled result holds the output register; the sequencer then waits.
`timescale 1ns / 1ps
`default_nettype none

module mesh_text_frame_encoder_core import mtfe_pkg::*; #(
  parameter int unsigned MaxPayload = MaxPayloadLen
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        push,
  output logic             full,
  input  wire logic        req_type_i,
  input  wire logic [7:0]  frame_length_i,
  input  wire logic [7:0]  data_byte_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       out_byte_o,
  output logic             end_of_frame_o,
  output logic [1:0]       status_o
);

  cmd_t front_cmd, q_cmd;
  logic front_push, q_full, q_valid, q_pop, accept;

  assign full   = q_full;
  assign accept = push && !q_full;

  mtfe_front #(
    .MaxPayload (MaxPayload)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .req_type_i     (req_type_i),
    .frame_length_i (frame_length_i),
    .data_byte_i    (data_byte_i),
    .cmd_o          (front_cmd),
    .cmd_push_o     (front_push)
  );

  mtfe_cmdq u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .cmd_i   (front_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  mtfe_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .cmd_valid_i    (q_valid),
    .cmd_i          (q_cmd),
    .cmd_pop_o      (q_pop),
    .pop_i          (pop),
    .empty_o        (empty),
    .out_byte_o     (out_byte_o),
    .end_of_frame_o (end_of_frame_o),
    .status_o       (status_o)
  );

endmodule

`default_nettype wire
